>>> rtl/checked_integer_alu_unit_assert.svh
// Assertion macros shared by the checked integer ALU checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef CHECKED_INTEGER_ALU_UNIT_ASSERT_SVH
`define CHECKED_INTEGER_ALU_UNIT_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define CAC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checked_integer_alu_unit assertion failed");

// Implication checked at every rising edge, reset included.
`define CAC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("checked_integer_alu_unit assertion failed");

`endif

>>> rtl/cac_pkg.sv
// Shared types and constants for the checked integer ALU.
// No dependencies.
`timescale 1ns / 1ps

package cac_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SHW        = $clog2(DATA_WIDTH);
    localparam int PW         = 2 * DATA_WIDTH + 2;

    typedef enum logic [3:0] {
        OP_SADD = 4'd0,
        OP_UADD = 4'd1,
        OP_SSUB = 4'd2,
        OP_USUB = 4'd3,
        OP_SMUL = 4'd4,
        OP_UMUL = 4'd5,
        OP_SDIV = 4'd6,
        OP_UDIV = 4'd7,
        OP_SREM = 4'd8,
        OP_UREM = 4'd9,
        OP_SSHR = 4'd10,
        OP_USHR = 4'd11,
        OP_SSHL = 4'd12,
        OP_USHL = 4'd13
    } op_t;

    // Per-item payload carried down the divider chain.
    typedef struct packed {
        logic                  is_div;
        logic                  is_rem;
        logic                  neg_res;
        logic [DATA_WIDTH-1:0] res;
        logic                  err;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] dvs;
    } lane_t;

endpackage

>>> rtl/checked_integer_alu_unit.sv
// Pipeline: DATA_WIDTH + 3 register stages (35): input, product, the divider cells and output.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// The divider is a chain of DATA_WIDTH cells, one quotient bit per cell.
// Reset (rst_n low, asynchronous) clears all valid bits; no item is in flight.
`timescale 1ns / 1ps

module checked_integer_alu_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [2*cac_pkg::DATA_WIDTH-1:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]                       s_tuser,   // [3:0] opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cac_pkg::DATA_WIDTH-1:0]   m_tdata,   // [31:0] result
    output logic                             m_tuser    // [0] error_flag
);

    localparam int W = cac_pkg::DATA_WIDTH;

    logic                   en;
    logic                   v1_reg;
    logic [3:0]             op_reg;
    logic [W-1:0]           a_reg;
    logic [W-1:0]           b_reg;
    cac_pkg::lane_t         f_lane;
    logic                   f_is_mul;
    logic                   f_mul_signed;
    logic [cac_pkg::PW-1:0] f_product;
    logic                   v2_reg;
    cac_pkg::lane_t         lane2_reg;
    logic                   is_mul_reg;
    logic                   mul_signed_reg;
    logic [cac_pkg::PW-1:0] product_reg;
    logic                   mul_err;
    logic                   chain_valid [W+1];
    cac_pkg::lane_t         chain_lane  [W+1];
    cac_pkg::lane_t         last;
    logic [W-1:0]           div_val;
    logic [W-1:0]           res_next;
    logic                   out_valid_reg;
    logic [W-1:0]           result_reg;
    logic                   err_reg;

    // Global advance: move when the output register is free or being taken.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= s_tuser;
            a_reg  <= s_tdata[W-1:0];
            b_reg  <= s_tdata[2*W-1:W];
        end
    end

    cac_front u_front
    (
        .opcode     (op_reg),
        .operand_a  (a_reg),
        .operand_b  (b_reg),
        .lane       (f_lane),
        .is_mul     (f_is_mul),
        .mul_signed (f_mul_signed),
        .product    (f_product)
    );

    // Product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane2_reg      <= f_lane;
            is_mul_reg     <= f_is_mul;
            mul_signed_reg <= f_mul_signed;
            product_reg    <= f_product;
        end
    end

    // Multiply overflow: upper product bits must all match the kept sign, or be zero.
    assign mul_err = mul_signed_reg
        ? !((product_reg[cac_pkg::PW-1:W-1] == '0) || (product_reg[cac_pkg::PW-1:W-1] == '1))
        : (product_reg[2*W-1:W] != '0);

    always_comb
    begin
        chain_valid[0] = v2_reg;
        chain_lane[0]  = lane2_reg;
        if (is_mul_reg)
        begin
            chain_lane[0].res = product_reg[W-1:0];
            chain_lane[0].err = mul_err;
        end
    end

    // Divider chain.
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        cac_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_lane   (chain_lane[i]),
            .out_valid (chain_valid[i+1]),
            .out_lane  (chain_lane[i+1])
        );
    end

    // Pick quotient or remainder and apply sign.
    assign last     = chain_lane[W];
    assign div_val  = last.is_rem ? last.rem : last.quo;
    assign res_next = !last.is_div ? last.res
                    : (last.neg_res ? (W'(0) - div_val) : div_val);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= res_next;
            err_reg    <= last.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;
    assign m_tuser  = err_reg;

endmodule

>>> rtl/cac_front.sv
// Operation decode, add/subtract/shift datapath and divider setup.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_front
(
    input  logic [3:0]                     opcode,
    input  logic [cac_pkg::DATA_WIDTH-1:0] operand_a,
    input  logic [cac_pkg::DATA_WIDTH-1:0] operand_b,
    output cac_pkg::lane_t                 lane,
    output logic                           is_mul,
    output logic                           mul_signed,
    output logic [cac_pkg::PW-1:0]         product
);

    localparam int W = cac_pkg::DATA_WIDTH;

    logic [W:0]                sum;
    logic [W:0]                diff;
    logic                      sa;
    logic                      sb;
    logic                      signed_op;
    logic [W-1:0]              mag_a;
    logic [W-1:0]              mag_b;
    logic                      sh_bad;
    logic [cac_pkg::SHW-1:0]   sh;
    logic                      div_bad;
    logic signed [W:0]         xa;
    logic signed [W:0]         xb;

    assign sum  = {1'b0, operand_a} + {1'b0, operand_b};
    assign diff = {1'b0, operand_a} - {1'b0, operand_b};
    assign sa   = operand_a[W-1];
    assign sb   = operand_b[W-1];
    assign sh   = operand_b[cac_pkg::SHW-1:0];

    // A shift amount with the sign bit set is also 32 or more unsigned.
    assign sh_bad = (operand_b >= W'(W));

    // Signed division and remainder work on magnitudes.
    assign signed_op = (opcode == cac_pkg::OP_SDIV) || (opcode == cac_pkg::OP_SREM);
    assign mag_a = (signed_op && sa) ? (W'(0) - operand_a) : operand_a;
    assign mag_b = (signed_op && sb) ? (W'(0) - operand_b) : operand_b;
    assign div_bad = (operand_b == '0)
        || (signed_op && (operand_a == {1'b1, {(W-1){1'b0}}}) && (operand_b == '1));

    // One shared multiplier, operands extended by one bit for sign.
    assign mul_signed = (opcode == cac_pkg::OP_SMUL);
    assign xa = $signed({mul_signed & sa, operand_a});
    assign xb = $signed({mul_signed & sb, operand_b});
    assign product = cac_pkg::PW'(xa * xb);

    // Decode and per-operation result.
    always_comb
    begin
        lane         = '0;
        lane.quo     = mag_a;
        lane.dvs     = mag_b;
        is_mul       = 1'b0;
        case (opcode)
            cac_pkg::OP_SADD:
            begin
                lane.res = sum[W-1:0];
                lane.err = (sa ^ sum[W-1]) & (sb ^ sum[W-1]);
            end
            cac_pkg::OP_UADD:
            begin
                lane.res = sum[W-1:0];
                lane.err = sum[W];
            end
            cac_pkg::OP_SSUB:
            begin
                lane.res = diff[W-1:0];
                lane.err = (sa ^ sb) & (sa ^ diff[W-1]);
            end
            cac_pkg::OP_USUB:
            begin
                lane.res = diff[W-1:0];
                lane.err = diff[W];
            end
            cac_pkg::OP_SMUL, cac_pkg::OP_UMUL:
            begin
                is_mul = 1'b1;
            end
            cac_pkg::OP_SDIV, cac_pkg::OP_UDIV, cac_pkg::OP_SREM, cac_pkg::OP_UREM:
            begin
                lane.err     = div_bad;
                lane.is_div  = !div_bad;
                lane.is_rem  = (opcode == cac_pkg::OP_SREM) || (opcode == cac_pkg::OP_UREM);
                lane.neg_res = (opcode == cac_pkg::OP_SDIV) ? (sa ^ sb)
                             : (opcode == cac_pkg::OP_SREM) ? sa : 1'b0;
            end
            cac_pkg::OP_SSHR:
            begin
                lane.err = sh_bad;
                lane.res = sh_bad ? {W{sa}} : W'($signed(operand_a) >>> sh);
            end
            cac_pkg::OP_USHR:
            begin
                lane.err = sh_bad;
                lane.res = sh_bad ? '0 : (operand_a >> sh);
            end
            cac_pkg::OP_SSHL, cac_pkg::OP_USHL:
            begin
                lane.err = sh_bad;
                lane.res = sh_bad ? '0 : (operand_a << sh);
            end
            default:
            begin
                lane.err = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/cac_div_cell.sv
// One restoring-division cell: develops one quotient bit per item.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_div_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cac_pkg::lane_t in_lane,
    output logic           out_valid,
    output cac_pkg::lane_t out_lane
);

    localparam int W = cac_pkg::DATA_WIDTH;

    logic           valid_reg;
    cac_pkg::lane_t lane_reg;
    cac_pkg::lane_t lane_next;
    logic [W:0]     trial;
    logic [W:0]     trial_sub;

    // Shift the next dividend bit into the partial remainder and try to subtract.
    assign trial     = {in_lane.rem, in_lane.quo[W-1]};
    assign trial_sub = trial - {1'b0, in_lane.dvs};

    always_comb
    begin
        lane_next = in_lane;
        if (!trial_sub[W])
        begin
            lane_next.rem = trial_sub[W-1:0];
            lane_next.quo = {in_lane.quo[W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem = trial[W-1:0];
            lane_next.quo = {in_lane.quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

>>> rtl/cac_checker.sv
// Port-level checks for the checked integer ALU, bound to the top level.
// Depends on cac_pkg and checked_integer_alu_unit_assert.svh.
`timescale 1ns / 1ps
`include "checked_integer_alu_unit_assert.svh"

module cac_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cac_pkg::DATA_WIDTH-1:0] m_tdata,
    input logic                           m_tuser
);

    // A stalled result item holds.
    `CAC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> $stable({m_tvalid, m_tdata, m_tuser}))
    // The pipeline stalls as a whole when the output is blocked.
    `CAC_ASSERT(a_stall_in, m_tvalid && !m_tready |-> !s_tready)
    // With the output register empty, input is always taken.
    `CAC_ASSERT(a_free_in, !m_tvalid |-> s_tready)
    // No result item is offered in the cycle after reset is seen.
    `CAC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid)

endmodule

bind checked_integer_alu_unit cac_checker u_cac_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
